### hdl/assert_macros.svh
// assertion helpers, empty when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

### hdl/svm_pkg.sv
//------------------------------------------------------------------------------
// svm_pkg
// shared types and constants of the sample voice mixer
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
package svm_pkg;
  localparam int SAMPLE_WORDS_DEF = 65536;
  localparam int NUM_BUFFERS_DEF  = 64;
  localparam int MAX_VOICES_DEF   = 64;

  localparam logic [1:0] ACT_WRITE  = 2'd0;
  localparam logic [1:0] ACT_DEFINE = 2'd1;
  localparam logic [1:0] ACT_START  = 2'd2;
  localparam logic [1:0] ACT_FRAME  = 2'd3;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_STARTED = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_UNKNOWN = 2'd3;

  localparam logic [1:0] REG_OUTPUT_CHANNELS = 2'd0;

  typedef enum logic [3:0] {
    S_IDLE, S_VREAD, S_DREAD, S_ADDR0, S_ADDR1, S_SLAST, S_LERP, S_MUL, S_ACC,
    S_FIN, S_OUT
  } state_t;

  // descriptor: start 16, frames 17, channels 3, step 24
  typedef struct packed {
    logic [15:0] start;
    logic [16:0] frames;
    logic [2:0]  channels;
    logic [23:0] step;
  } desc_t;

  function automatic logic signed [23:0] sat24(input logic signed [47:0] v);
    if (v > 48'sd8388607) return 24'sh7FFFFF;
    if (v < -48'sd8388608) return 24'sh800000;
    return v[23:0];
  endfunction
endpackage

### hdl/svm_ram.sv
//------------------------------------------------------------------------------
// svm_ram
// generic single-port-write, single-read ram with registered read
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module svm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### hdl/sample_voice_mixer_core.sv
//------------------------------------------------------------------------------
// sample_voice_mixer_core
// sample playback mixer with linear interpolation over a voice table in ram
//------------------------------------------------------------------------------
// write, define and start pass from voice read to output; a frame takes
// each active voice through descriptor read, address, sample reads, lerp,
// multiply, accumulate (four reads on one port for stereo multichannel)
// one transaction at a time; ready returns when the result register loads,
// a result still waiting there holds the next one at its output step only
// reset: voice count zero, buffer valid bits cleared, output channels 2
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sample_voice_mixer_core #(
  parameter int SAMPLE_WORDS = svm_pkg::SAMPLE_WORDS_DEF,
  parameter int NUM_BUFFERS  = svm_pkg::NUM_BUFFERS_DEF,
  parameter int MAX_VOICES   = svm_pkg::MAX_VOICES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_action,
  input  logic [15:0]         in_address,
  input  logic signed [15:0]  in_sample,
  input  logic [5:0]          in_buffer_id,
  input  logic [15:0]         in_buffer_start,
  input  logic [16:0]         in_buffer_frames,
  input  logic [2:0]          in_buffer_channels,
  input  logic [23:0]         in_rate_step,
  input  logic [15:0]         in_gain_left,
  input  logic [15:0]         in_gain_right,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_status,
  output logic signed [23:0]  out_mix_left,
  output logic signed [23:0]  out_mix_right,
  output logic [6:0]          out_active_voices,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [1:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);
  import svm_pkg::*;

  localparam int AW = $clog2(SAMPLE_WORDS);
  localparam int BW = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
  localparam int VW = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
  localparam int CW = $clog2(MAX_VOICES + 1);
  localparam int VEW = 6 + 33 + 32;
  localparam int DW = $bits(desc_t);

  // config
  logic [1:0] och_r;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = {30'd0, och_r};
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      och_r <= 2'd2;
    end else if (cfg_psel && cfg_penable && cfg_pwrite
                 && cfg_paddr == 2'(REG_OUTPUT_CHANNELS * 4)) begin
      och_r <= cfg_pwdata[1:0];
    end
  end
  wire stereo_out = och_r[1];

  state_t state_r, state_nxt;

  // captured input
  logic [1:0]  act_r;
  logic [15:0] addr_in_r, smp_in_r, gl_r, gr_r;
  logic [5:0]  bid_r;
  desc_t       ndesc_r;

  // buffer valid bits
  logic [NUM_BUFFERS-1:0] bvalid_r;
  logic [CW-1:0] vcount_r, keep_r, vidx_r;

  // per voice working registers
  logic [VEW-1:0] ventry_r;
  desc_t          d_r;
  logic [16:0]    i0_r, i1_r;
  logic [15:0]    frac_r;
  logic [1:0]     rd_r;    // sample read index: l0 l1 r0 r1
  logic signed [15:0] s_r [4];
  logic signed [15:0] sl_r, sr_r;
  logic signed [47:0] accl_r, accr_r;
  logic [1:0]  st_r;
  logic signed [23:0] ol_r, or_r;
  logic ovalid_r;

  // result register
  logic [1:0]         ost_r;
  logic signed [23:0] oleft_r, oright_r;
  logic [6:0]         onum_r;

  // rams
  logic          smem_we;
  logic [AW-1:0] smem_wa, smem_ra;
  logic [15:0]   smem_rd;
  logic          dmem_we;
  logic [BW-1:0] dmem_ra;
  desc_t         dmem_rd;
  logic          vmem_we;
  logic [VW-1:0] vmem_wa, vmem_ra;
  logic [VEW-1:0] vmem_wd, vmem_rd;

  svm_ram #(.WIDTH(16), .DEPTH(SAMPLE_WORDS)) u_smem (
    .clk, .we(smem_we), .waddr(smem_wa), .wdata(smp_in_r), .raddr(smem_ra),
    .rdata(smem_rd));
  svm_ram #(.WIDTH(DW), .DEPTH(NUM_BUFFERS)) u_dmem (
    .clk, .we(dmem_we), .waddr(bid_r[BW-1:0]), .wdata(ndesc_r), .raddr(dmem_ra),
    .rdata(dmem_rd));
  svm_ram #(.WIDTH(VEW), .DEPTH(MAX_VOICES)) u_vmem (
    .clk, .we(vmem_we), .waddr(vmem_wa), .wdata(vmem_wd), .raddr(vmem_ra),
    .rdata(vmem_rd));

  // voice entry fields
  wire [5:0]  ve_buf = ventry_r[70:65];
  wire [32:0] ve_pos = ventry_r[64:32];
  wire [15:0] ve_gl  = ventry_r[31:16];
  wire [15:0] ve_gr  = ventry_r[15:0];

  wire bid_ok = ({26'd0, bid_r} < 32'(NUM_BUFFERS));
  wire bid_valid = bid_ok && bvalid_r[bid_r[BW-1:0]];

  // sample address for read index
  logic [2:0]  ch_a;
  logic [16:0] fr_a;
  logic [39:0] sa_full;
  always_comb begin
    fr_a = rd_r[0] ? i1_r : i0_r;
    ch_a = {2'd0, rd_r[1]};
    sa_full = 40'(d_r.start) + 40'(fr_a) * 40'(d_r.channels) + 40'(ch_a);
  end
  assign smem_ra = sa_full[AW-1:0];

  // interpolation and products
  logic signed [16:0] dl, dr;
  logic signed [33:0] pl, pr;
  logic signed [17:0] il, ir;
  logic signed [15:0] sl, sr;
  logic signed [32:0] ml, mr;
  logic [33:0] npos;
  logic [16:0] last;
  always_comb begin
    dl = 17'(s_r[1]) - 17'(s_r[0]);
    dr = 17'(s_r[3]) - 17'(s_r[2]);
    pl = 34'(dl) * $signed({18'd0, frac_r});
    pr = 34'(dr) * $signed({18'd0, frac_r});
    il = 18'(s_r[0]) + 18'(pl >>> 16);
    ir = 18'(s_r[2]) + 18'(pr >>> 16);
    sl = il[15:0];
    sr = (stereo_out && d_r.channels > 3'd1) ? ir[15:0] : sl;
    ml = 33'(sl_r) * $signed({17'd0, ve_gl});
    mr = 33'(sr_r) * $signed({17'd0, ve_gr});
    npos = {1'b0, ve_pos} + 34'(d_r.step);
    last = d_r.frames - 17'd1;
  end

  logic keep_voice;
  assign keep_voice = (npos[33:16] < {1'b0, d_r.frames});

  logic last_rd;
  assign last_rd = (stereo_out && d_r.channels > 3'd1) ? (rd_r == 2'd3) : (rd_r == 2'd1);

  always_comb begin
    state_nxt = state_r;
    smem_we = 1'b0;
    smem_wa = AW'(addr_in_r);
    dmem_we = 1'b0;
    dmem_ra = ve_buf[BW-1:0];
    vmem_we = 1'b0;
    vmem_wa = vcount_r[VW-1:0];
    vmem_wd = {bid_r, 33'd0, gl_r, gr_r};
    vmem_ra = vidx_r[VW-1:0];
    case (state_r)
      S_IDLE: begin
        vmem_ra = '0;
        if (in_valid && in_ready) state_nxt = S_VREAD;
      end
      S_VREAD: begin
        case (act_r)
          ACT_WRITE: begin smem_we = 1'b1; state_nxt = S_OUT; end
          ACT_DEFINE: begin dmem_we = bid_ok; state_nxt = S_OUT; end
          ACT_START: begin
            vmem_we = (vcount_r < CW'(MAX_VOICES)) && bid_valid;
            state_nxt = S_OUT;
          end
          default: state_nxt = (vidx_r < vcount_r) ? S_DREAD : S_FIN;
        endcase
      end
      S_DREAD: state_nxt = S_ADDR0;
      S_ADDR0: state_nxt = S_ADDR1;
      S_ADDR1: state_nxt = last_rd ? S_SLAST : S_ADDR1;
      S_SLAST: state_nxt = S_LERP;
      S_LERP: state_nxt = S_MUL;
      S_MUL: state_nxt = S_ACC;
      S_ACC: begin
        vmem_we = keep_voice;
        vmem_wa = keep_r[VW-1:0];
        vmem_wd = {ve_buf, npos[32:0], ve_gl, ve_gr};
        vmem_ra = VW'(vidx_r + CW'(1));
        state_nxt = S_VREAD;
      end
      S_FIN: state_nxt = S_OUT;
      S_OUT: if (!ovalid_r || out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_ready = (state_r == S_IDLE);
  logic signed [32:0] mlr_r, mrr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      bvalid_r <= '0;
      vcount_r <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_OUT && (!ovalid_r || out_ready)) ovalid_r <= 1'b1;
      else if (out_ready) ovalid_r <= 1'b0;
      if (state_r == S_VREAD && act_r == ACT_DEFINE && bid_ok)
        bvalid_r[bid_r[BW-1:0]] <= 1'b1;
      if (state_r == S_VREAD && act_r == ACT_START
          && vcount_r < CW'(MAX_VOICES) && bid_valid)
        vcount_r <= vcount_r + CW'(1);
      if (state_r == S_FIN) vcount_r <= keep_r;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        act_r <= in_action; addr_in_r <= in_address; smp_in_r <= in_sample;
        bid_r <= in_buffer_id; gl_r <= in_gain_left; gr_r <= in_gain_right;
        ndesc_r.start <= in_buffer_start;
        ndesc_r.frames <= (in_buffer_frames == 17'd0) ? 17'd1 : in_buffer_frames;
        ndesc_r.channels <= (in_buffer_channels == 3'd0) ? 3'd1 : in_buffer_channels;
        ndesc_r.step <= in_rate_step;
        vidx_r <= '0; keep_r <= '0; accl_r <= '0; accr_r <= '0;
        st_r <= ST_DONE;
      end
      S_VREAD: begin
        ventry_r <= vmem_rd;
        if (act_r == ACT_START)
          st_r <= (vcount_r >= CW'(MAX_VOICES)) ? ST_FULL
                  : (!bid_valid ? ST_UNKNOWN : ST_STARTED);
      end
      S_DREAD: ;
      S_ADDR0: begin
        d_r <= dmem_rd;
        rd_r <= 2'd0;
        i0_r <= (ve_pos[32:16] > dmem_rd.frames - 17'd1) ? dmem_rd.frames - 17'd1
                : ve_pos[32:16];
        frac_r <= ve_pos[15:0];
      end
      S_ADDR1: begin
        rd_r <= rd_r + 2'd1;
        if (rd_r == 2'd0) i1_r <= (i0_r + 17'd1 > last || i0_r == 17'h1FFFF) ? last
                                  : i0_r + 17'd1;
      end
      S_LERP: begin sl_r <= sl; sr_r <= sr; end
      S_MUL: begin mlr_r <= ml; mrr_r <= mr; end
      S_ACC: begin
        accl_r <= accl_r + 48'(mlr_r);
        if (stereo_out) accr_r <= accr_r + 48'(mrr_r);
        if (keep_voice) keep_r <= keep_r + CW'(1);
        vidx_r <= vidx_r + CW'(1);
      end
      S_FIN: begin
        ol_r <= sat24(accl_r >>> 7);
        or_r <= sat24(accr_r >>> 7);
      end
      S_OUT: begin
        if (!ovalid_r || out_ready) begin
          ost_r <= st_r;
          oleft_r <= ol_r;
          oright_r <= or_r;
          onum_r <= 7'(vcount_r);
        end
      end
      default: ;
    endcase
    if ((state_r == S_ADDR1 && rd_r != 2'd0) || state_r == S_SLAST)
      s_r[rd_r - 2'd1] <= smem_rd;
    if (state_r == S_IDLE) begin ol_r <= '0; or_r <= '0; end
  end

  assign out_valid = ovalid_r;
  assign out_status = ost_r;
  assign out_mix_left = oleft_r;
  assign out_mix_right = oright_r;
  assign out_active_voices = onum_r;

  logic [56:0] out_bus;
  assign out_bus = {out_status, out_mix_left, out_mix_right, out_active_voices};

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_bus))
  `ASSERT_NEXT(a_in_once, clk, rst_n, in_valid && in_ready, !in_ready)
  `ASSERT_IMPLIES(a_vcount_max, clk, rst_n, 1'b1, vcount_r <= CW'(MAX_VOICES))
  `ASSERT_IMPLIES(a_keep_order, clk, rst_n, state_r == S_ACC, keep_r <= vidx_r)
endmodule
